FILE: rtl/core/lpgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgd_pkg
// Shared types and constants of the long-press gesture detector.
// ----------------------------------------------------------------------------
package lpgd_pkg;

    // Input item actions
    localparam logic [2:0] ACT_X    = 3'd0;
    localparam logic [2:0] ACT_Y    = 3'd1;
    localparam logic [2:0] ACT_DOWN = 3'd2;
    localparam logic [2:0] ACT_UP   = 3'd3;
    localparam logic [2:0] ACT_TICK = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_ARM    = 3'd0;
    localparam logic [2:0] KIND_RESIZE = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_RCLICK = 3'd3;
    localparam logic [2:0] KIND_HIDE   = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_ARM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION    = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] RST_PRE_ARM = 16'd500;
    localparam logic [15:0] RST_ANIM    = 16'd500;
    localparam logic [9:0]  RST_SQUARE  = 10'd40;
    localparam logic [7:0]  RST_LINE    = 8'd2;
    localparam logic [7:0]  RST_MOTION  = 8'd18;

    // Size divider: the quotient always fits in the indicator width
    localparam int SIZE_W    = 10;
    localparam int DIV_STEPS = SIZE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = 27;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] coord;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [9:0]  indicator_size;
    } t_out_item;

    typedef struct packed {
        logic [15:0] pre_arm_ticks;
        logic [15:0] animation_ticks;
        logic [9:0]  square_size;
        logic [7:0]  line_width;
        logic [7:0]  motion_limit;
    } t_cfg;

    // Queue head handed from front to back
    typedef struct packed {
        logic        valid;
        logic [2:0]  action;
        logic [15:0] coord;
    } t_q_head;

endpackage

FILE: rtl/core/lpgd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgd_front
// Accepts input items, drops unknown actions and queues the rest.
// ----------------------------------------------------------------------------
module lpgd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lpgd_pkg::t_in_item  i_item,
    output lpgd_pkg::t_q_head   o_head,
    input  logic                i_pop
);

    lpgd_pkg::t_in_item r_mem [lpgd_pkg::Q_DEPTH];
    logic [lpgd_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [lpgd_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [lpgd_pkg::Q_CNT_W-1:0] r_count;

    logic accept;
    logic known;
    logic push;
    logic pop;

    assign o_stall = (r_count == lpgd_pkg::Q_CNT_W'(lpgd_pkg::Q_DEPTH));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        case (i_item.action)
            lpgd_pkg::ACT_X,
            lpgd_pkg::ACT_Y,
            lpgd_pkg::ACT_DOWN,
            lpgd_pkg::ACT_UP,
            lpgd_pkg::ACT_TICK: known = 1'b1;
            default:            known = 1'b0;
        endcase
    end

    assign push = accept && known;
    assign pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid  = (r_count != '0);
    assign o_head.action = r_mem[r_rd_ptr].action;
    assign o_head.coord  = r_mem[r_rd_ptr].coord;

endmodule

FILE: rtl/core/lpgd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgd_back
// Press state machine: motion check, arming, indicator size, result register.
// ----------------------------------------------------------------------------
module lpgd_back #(
    parameter int START_SIZE = 10,
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpgd_pkg::t_q_head                   i_head,
    output logic                                o_pop,
    input  logic                                i_cfg_we,
    input  logic [lpgd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpgd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lpgd_pkg::t_out_item                 o_item
);

    localparam int CB = COORD_BITS;
    localparam int MW = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int PW = 2 * MW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_SQX    = 4'd2;
    localparam logic [3:0] S_SQY    = 4'd3;
    localparam logic [3:0] S_SQT    = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_SZMUL  = 4'd6;
    localparam logic [3:0] S_SZPREP = 4'd7;
    localparam logic [3:0] S_SZDIV  = 4'd8;
    localparam logic [3:0] S_SZFIN  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    localparam logic [9:0] START_V = 10'(START_SIZE);

    lpgd_pkg::t_cfg r_cfg;

    logic [3:0]  r_state;
    logic [2:0]  r_action;
    logic [15:0] r_coord;

    logic r_finger;
    logic r_armed;
    logic r_cancelled;
    logic r_complete;
    logic r_seen_x;
    logic r_seen_y;

    logic [CB-1:0] r_cur_x;
    logic [CB-1:0] r_cur_y;
    logic [CB-1:0] r_anchor_x;
    logic [CB-1:0] r_anchor_y;
    logic [CB-1:0] r_latched_x;
    logic [CB-1:0] r_latched_y;
    logic [15:0]   r_press;
    logic [15:0]   r_anim;

    logic [PW-1:0] r_sx;
    logic [PW-1:0] r_sy;
    logic [PW-1:0] r_thr;
    logic [PW-1:0] r_prod;

    logic [lpgd_pkg::REM_W-1:0]     r_rem;
    logic [lpgd_pkg::REM_W-1:0]     r_dvs;
    logic [lpgd_pkg::SIZE_W-1:0]    r_quo;
    logic [lpgd_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [2:0]                  r_kind;
    logic [lpgd_pkg::SIZE_W-1:0] r_size;

    logic                r_out_valid;
    lpgd_pkg::t_out_item r_out;

    logic [15:0]   dur;
    logic [15:0]   elapsed;
    logic [9:0]    span;
    logic [CB-1:0] dx;
    logic [CB-1:0] dy;
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [PW:0]   dist_sum;
    logic [15:0]   n_press;
    logic [16:0]   anim_inc;
    logic [15:0]   n_anim;
    logic [10:0]   size_raw;
    logic [9:0]    size_floor;
    logic [9:0]    n_size;
    logic [CB-1:0] coord_c;
    logic          out_free;

    // Duration is never below one tick
    assign dur     = (r_cfg.animation_ticks == '0) ? 16'd1 : r_cfg.animation_ticks;
    assign elapsed = (r_anim < dur) ? r_anim : dur;
    assign span    = (r_cfg.square_size > START_V) ? (r_cfg.square_size - START_V) : 10'd0;
    assign dx      = (r_cur_x > r_anchor_x) ? (r_cur_x - r_anchor_x) : (r_anchor_x - r_cur_x);
    assign dy      = (r_cur_y > r_anchor_y) ? (r_cur_y - r_anchor_y) : (r_anchor_y - r_cur_y);
    assign coord_c = CB'(r_coord);

    // Shared multiplier
    always_comb begin
        case (r_state)
            S_SQX: begin
                mul_a = MW'(dx);
                mul_b = MW'(dx);
            end
            S_SQY: begin
                mul_a = MW'(dy);
                mul_b = MW'(dy);
            end
            S_SQT: begin
                mul_a = MW'(r_cfg.motion_limit);
                mul_b = MW'(r_cfg.motion_limit);
            end
            S_SZMUL: begin
                mul_a = MW'(elapsed);
                mul_b = MW'(span);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign dist_sum = {1'b0, r_sx} + {1'b0, r_sy};

    assign n_press  = (r_press != 16'hFFFF) ? (r_press + 16'd1) : r_press;
    assign anim_inc = {1'b0, r_anim} + 17'd1;
    assign n_anim   = (anim_inc < {1'b0, dur}) ? anim_inc[15:0] : dur;

    assign size_raw   = {1'b0, START_V} + {1'b0, r_quo};
    assign size_floor = {1'b0, r_cfg.line_width, 1'b0};
    assign n_size     = (size_raw < {1'b0, size_floor}) ? size_floor : size_raw[9:0];

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_arm_ticks   <= lpgd_pkg::RST_PRE_ARM;
            r_cfg.animation_ticks <= lpgd_pkg::RST_ANIM;
            r_cfg.square_size     <= lpgd_pkg::RST_SQUARE;
            r_cfg.line_width      <= lpgd_pkg::RST_LINE;
            r_cfg.motion_limit    <= lpgd_pkg::RST_MOTION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpgd_pkg::CFG_PRE_ARM: r_cfg.pre_arm_ticks   <= i_cfg_data;
                lpgd_pkg::CFG_ANIM:    r_cfg.animation_ticks <= i_cfg_data;
                lpgd_pkg::CFG_SQUARE:  r_cfg.square_size     <= i_cfg_data[9:0];
                lpgd_pkg::CFG_LINE:    r_cfg.line_width      <= i_cfg_data[7:0];
                lpgd_pkg::CFG_MOTION:  r_cfg.motion_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= i_head.action;
            r_coord  <= i_head.coord;
        end
        case (r_state)
            S_SQX:   r_sx   <= mul_p;
            S_SQY:   r_sy   <= mul_p;
            S_SQT:   r_thr  <= mul_p;
            S_SZMUL: r_prod <= mul_p;
            S_SZPREP: begin
                r_rem <= lpgd_pkg::REM_W'(r_prod) + lpgd_pkg::REM_W'(dur >> 1);
                r_dvs <= lpgd_pkg::REM_W'({dur, {(lpgd_pkg::DIV_STEPS - 1){1'b0}}});
                r_quo <= '0;
            end
            S_SZDIV: begin
                if (r_rem >= r_dvs) begin
                    r_rem <= r_rem - r_dvs;
                    r_quo <= {r_quo[lpgd_pkg::SIZE_W-2:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[lpgd_pkg::SIZE_W-2:0], 1'b0};
                end
                r_dvs <= r_dvs >> 1;
            end
            default: ;
        endcase
        if (r_state == S_EMIT && out_free) begin
            r_out.kind           <= r_kind;
            r_out.pos_x          <= 16'(r_latched_x);
            r_out.pos_y          <= 16'(r_latched_y);
            r_out.indicator_size <= r_size;
        end
    end

    // Press state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finger    <= 1'b0;
            r_armed     <= 1'b0;
            r_cancelled <= 1'b0;
            r_complete  <= 1'b0;
            r_seen_x    <= 1'b0;
            r_seen_y    <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_anchor_x  <= '0;
            r_anchor_y  <= '0;
            r_latched_x <= '0;
            r_latched_y <= '0;
            r_press     <= '0;
            r_anim      <= '0;
            r_cnt       <= '0;
            r_kind      <= lpgd_pkg::KIND_ARM;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_action)
                        lpgd_pkg::ACT_X: begin
                            r_cur_x  <= coord_c;
                            r_seen_x <= 1'b1;
                            if (r_finger && !r_cancelled && r_seen_y) begin
                                r_state <= S_SQX;
                            end
                        end
                        lpgd_pkg::ACT_Y: begin
                            r_cur_y  <= coord_c;
                            r_seen_y <= 1'b1;
                            if (r_finger && !r_cancelled && r_seen_x) begin
                                r_state <= S_SQX;
                            end
                        end
                        lpgd_pkg::ACT_DOWN: begin
                            if (r_armed) begin
                                r_kind  <= lpgd_pkg::KIND_HIDE;
                                r_size  <= '0;
                                r_state <= S_EMIT;
                            end
                            r_finger    <= 1'b1;
                            r_armed     <= 1'b0;
                            r_cancelled <= 1'b0;
                            r_complete  <= 1'b0;
                            r_press     <= '0;
                            r_anim      <= '0;
                            r_anchor_x  <= r_cur_x;
                            r_anchor_y  <= r_cur_y;
                        end
                        lpgd_pkg::ACT_UP: begin
                            if (r_complete) begin
                                r_kind  <= lpgd_pkg::KIND_RCLICK;
                                r_size  <= '0;
                                r_state <= S_EMIT;
                            end else if (r_armed) begin
                                r_kind  <= lpgd_pkg::KIND_HIDE;
                                r_size  <= '0;
                                r_state <= S_EMIT;
                            end
                            r_finger    <= 1'b0;
                            r_armed     <= 1'b0;
                            r_cancelled <= 1'b0;
                            r_complete  <= 1'b0;
                            r_press     <= '0;
                            r_anim      <= '0;
                            r_seen_x    <= 1'b0;
                            r_seen_y    <= 1'b0;
                        end
                        lpgd_pkg::ACT_TICK: begin
                            if (r_finger && !r_armed && !r_cancelled) begin
                                r_press <= n_press;
                                if (n_press >= r_cfg.pre_arm_ticks) begin
                                    r_armed     <= 1'b1;
                                    r_anim      <= '0;
                                    r_latched_x <= r_cur_x;
                                    r_latched_y <= r_cur_y;
                                    r_kind      <= lpgd_pkg::KIND_ARM;
                                    r_state     <= S_SZMUL;
                                end
                            end else if (r_finger && r_armed) begin
                                r_anim <= n_anim;
                                if (n_anim >= dur) begin
                                    r_complete <= 1'b1;
                                end
                                r_kind  <= lpgd_pkg::KIND_RESIZE;
                                r_state <= S_SZMUL;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: r_state <= S_SQT;
                S_SQT: r_state <= S_CMP;
                S_CMP: begin
                    r_state <= S_IDLE;
                    if (dist_sum > {1'b0, r_thr}) begin
                        r_cancelled <= 1'b1;
                        if (r_armed) begin
                            r_armed    <= 1'b0;
                            r_complete <= 1'b0;
                            r_kind     <= lpgd_pkg::KIND_CANCEL;
                            r_size     <= '0;
                            r_state    <= S_EMIT;
                        end
                    end
                end
                S_SZMUL:  r_state <= S_SZPREP;
                S_SZPREP: begin
                    r_cnt   <= '0;
                    r_state <= S_SZDIV;
                end
                S_SZDIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == lpgd_pkg::DIV_CNT_W'(lpgd_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_SZFIN;
                    end
                end
                S_SZFIN: begin
                    r_size  <= n_size;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_armed_needs_finger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_finger)
        else $error("armed without finger down");

    a_complete_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> r_armed)
        else $error("complete without armed");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SZFIN) |-> (r_rem < lpgd_pkg::REM_W'(dur)))
        else $error("size divider remainder out of range");

    a_no_pop_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while busy");

endmodule

FILE: rtl/core/long_press_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_press_gesture_detector
// Long-press touch gesture detector: arming, indicator growth, cancel, click.
// ----------------------------------------------------------------------------
// Feed touch items (x sample, y sample, finger down, finger up, millisecond
// tick) on the input channel; results come out one per causing item on the
// output channel. Unknown actions are accepted and dropped. Items enter a
// two-entry queue and the press engine works one item at a time: each item
// passes the idle and execute states, a sample that triggers the motion check
// also the squaring states for x, y and limit and a compare, and a tick that
// reports a size runs the 10-step serial divider that rounds indicator size.
// Results wait in an output register until taken; the queue keeps filling.
// Write configuration only while the block is idle.
module long_press_gesture_detector #(
    parameter int START_SIZE = 10,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  lpgd_pkg::t_in_item               i_item,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output lpgd_pkg::t_out_item              o_item,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [lpgd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lpgd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lpgd_pkg::t_q_head head;
    logic              pop;

    // Front: accept, drop unknown actions, queue the rest
    lpgd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back: press state, motion check, size arithmetic, result register
    lpgd_back #(
        .START_SIZE (START_SIZE),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule
